// ===== design/cpi_pkg.sv =====
// Shared types and constants for the cyclic prefix inserter.
package cpi_pkg;

    localparam int WORD_BITS  = 64;
    localparam int HALF_BITS  = 32;
    localparam int FIELD_BITS = 32;

    // Frame parameter ids carried in header words
    localparam int PID_FRAME_LEN   = 0;
    localparam int PID_SYMBOLS     = 1;
    localparam int PID_PILOT       = 2;
    localparam int PID_PREFIX_LEN  = 3;

    typedef struct packed {
        logic                  start;
        logic [FIELD_BITS-1:0] dividend;
        logic [FIELD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [FIELD_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/cpi_in_if.sv =====
// Input stream channel: one 64-bit word per item.
interface cpi_in_if;
    import cpi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] in_word;

    modport source (output valid, output in_word, input ready);
    modport sink   (input valid, input in_word, output ready);
endinterface

// ===== design/cpi_out_if.sv =====
// Output stream channel: one 64-bit word and an end-of-run flag per item.
interface cpi_out_if;
    import cpi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] out_word;
    logic                 last_of_run;

    modport source (output valid, output out_word, output last_of_run, input ready);
    modport sink   (input valid, input out_word, input last_of_run, output ready);
endinterface

// ===== design/cpi_buf.sv =====
// Symbol buffer: one write port, one read port with registered read data.
module cpi_buf #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/cpi_div.sv =====
// Restoring divider, one quotient bit per cycle, for the symbol count.
module cpi_div (
    input  logic                clk,
    input  logic                rst_n,
    input  cpi_pkg::div_req_t   req,
    output cpi_pkg::div_rsp_t   rsp
);
    import cpi_pkg::*;

    localparam int CNT_BITS = $clog2(FIELD_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [FIELD_BITS-1:0] rem_reg, rem_next;
    logic [FIELD_BITS-1:0] quo_reg, quo_next;
    logic [FIELD_BITS-1:0] dsr_reg, dsr_next;
    logic [FIELD_BITS:0]   rem_sh;
    logic [FIELD_BITS:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        rem_sh    = {rem_reg, quo_reg[FIELD_BITS-1]};
        diff      = rem_sh - {1'b0, dsr_reg};

        if (busy_reg)
        begin
            // keep the partial remainder, shift in one quotient bit
            rem_next = diff[FIELD_BITS] ? rem_sh[FIELD_BITS-1:0] : diff[FIELD_BITS-1:0];
            quo_next = {quo_reg[FIELD_BITS-2:0], ~diff[FIELD_BITS]};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(FIELD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/cyclic_prefix_inserter.sv =====
// Cyclic prefix inserter top level: header parsing, symbol buffering and readout.
// Latency: forwarded header words and echoed samples are registered and show on the output the cycle after their item.
// Input: header words and samples are taken in ST_RUN while the output register is free;
// the last sample of a symbol starts a readout through the single buffer read port, and
// the word that ends the header starts the product and any divides; input waits on both.
// Reset: asynchronous, clears control and frame parameters; the buffer is not cleared.
module cyclic_prefix_inserter #(
    parameter int SYMBOL_LEN       = 32,
    parameter int SAMPLE_BITS      = 16,
    parameter int OWN_MODULE_ID    = 5,
    parameter int MODULE_ID_BITS   = 8,
    parameter int PARAM_ID_BITS    = 24,
    parameter int PARAM_VALUE_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    cpi_in_if.sink    sample_ch,
    cpi_out_if.source result_ch
);
    import cpi_pkg::*;

    localparam int POS_BITS   = $clog2(SYMBOL_LEN);
    localparam int CNT_BITS   = $clog2(SYMBOL_LEN + 1);
    localparam int ENTRY_BITS = 2 * SAMPLE_BITS;
    localparam int HDR_SHIFT  = PARAM_ID_BITS + PARAM_VALUE_BITS;

    localparam logic [POS_BITS-1:0]   LAST_POS = POS_BITS'(SYMBOL_LEN - 1);
    localparam logic [CNT_BITS-1:0]   DUMP_END = CNT_BITS'(SYMBOL_LEN);
    localparam logic [WORD_BITS-1:0]  OWN_ID   = WORD_BITS'(OWN_MODULE_ID);
    localparam logic [WORD_BITS-1:0]  END_ID   =
        (WORD_BITS'(1) << MODULE_ID_BITS) - WORD_BITS'(1);
    localparam logic [FIELD_BITS-1:0] SYM_LEN_F = FIELD_BITS'(SYMBOL_LEN);

    typedef enum logic [2:0] {
        ST_RUN,     // take header words or samples
        ST_MUL,     // form frame length * symbols per frame
        ST_DIV1,    // SYMBOL_LEN / pilot_spacing
        ST_DIV2,    // product / data carriers
        ST_DUMP     // read the buffered symbol out
    } state_t;

    state_t                state_reg, state_next;
    logic                  phase_reg, phase_next;
    logic [FIELD_BITS-1:0] frame_len_reg, frame_len_next;
    logic [FIELD_BITS-1:0] symbols_reg, symbols_next;
    logic [FIELD_BITS-1:0] pilot_reg, pilot_next;
    logic [FIELD_BITS-1:0] prefix_reg, prefix_next;
    logic [FIELD_BITS-1:0] left_reg, left_next;
    logic [FIELD_BITS-1:0] prod_reg, prod_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [CNT_BITS-1:0]   rd_cnt_reg, rd_cnt_next;
    logic                  pend_reg, pend_next;
    logic                  pend_last_reg, pend_last_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]  out_word_reg, out_word_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic                  accept;
    logic [WORD_BITS-1:0]  mid;
    logic [WORD_BITS-1:0]  pid_sh;
    logic [PARAM_ID_BITS-1:0] pid;
    logic [FIELD_BITS-1:0] pval;
    logic [SAMPLE_BITS-1:0] re, im;
    logic                  echo;
    logic [FIELD_BITS-1:0] carriers;
    logic                  issue;
    logic                  push;
    logic [SAMPLE_BITS-1:0] rd_re, rd_im;
    logic [ENTRY_BITS-1:0] rd_data;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // The output register takes a new result when empty or being drained.
    assign out_free = !out_valid_reg || result_ch.ready;
    assign sample_ch.ready = (state_reg == ST_RUN) && out_free;
    assign accept = sample_ch.valid && sample_ch.ready;

    // Header word fields
    assign mid    = sample_ch.in_word >> HDR_SHIFT;
    assign pid_sh = sample_ch.in_word >> PARAM_VALUE_BITS;
    assign pid    = pid_sh[PARAM_ID_BITS-1:0];
    assign pval   = FIELD_BITS'(sample_ch.in_word[PARAM_VALUE_BITS-1:0]);

    // Sample fields
    assign re = sample_ch.in_word[HALF_BITS +: SAMPLE_BITS];
    assign im = sample_ch.in_word[SAMPLE_BITS-1:0];

    // Echo the sample as cyclic prefix when it sits in the tail of the symbol.
    assign echo = ({1'b0, prefix_reg} + (FIELD_BITS + 1)'(pos_reg))
                  >= (FIELD_BITS + 1)'(SYMBOL_LEN);

    // Data carriers per symbol once SYMBOL_LEN / pilot_spacing is known.
    assign carriers = SYM_LEN_F - div_rsp.quotient;

    // Readout: issue a read when the held read data is free or leaves this cycle.
    assign push  = pend_reg && out_free;
    assign issue = (state_reg == ST_DUMP) && (rd_cnt_reg != DUMP_END)
                   && (!pend_reg || push);

    assign rd_re = rd_data[ENTRY_BITS-1:SAMPLE_BITS];
    assign rd_im = rd_data[SAMPLE_BITS-1:0];

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = carriers;
        if (state_reg == ST_MUL)
        begin
            div_req.start    = (pilot_reg != '0);
            div_req.dividend = SYM_LEN_F;
            div_req.divisor  = pilot_reg;
        end
        else if (state_reg == ST_DIV1)
        begin
            div_req.start = div_rsp.done && (carriers != '0);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        symbols_next   = symbols_reg;
        pilot_next     = pilot_reg;
        prefix_next    = prefix_reg;
        left_next      = left_reg;
        prod_next      = prod_reg;
        pos_next       = pos_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (accept && !phase_reg)
                begin
                    if (mid == OWN_ID)
                    begin
                        // absorb: set one frame parameter, drop unknown ids
                        if (pid == PARAM_ID_BITS'(PID_FRAME_LEN))
                        begin
                            frame_len_next = pval;
                        end
                        else if (pid == PARAM_ID_BITS'(PID_SYMBOLS))
                        begin
                            symbols_next = pval;
                        end
                        else if (pid == PARAM_ID_BITS'(PID_PILOT))
                        begin
                            pilot_next = pval;
                        end
                        else if (pid == PARAM_ID_BITS'(PID_PREFIX_LEN))
                        begin
                            prefix_next = pval;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = sample_ch.in_word;
                        out_last_next  = 1'b1;
                    end
                    if (mid == END_ID)
                    begin
                        pos_next   = '0;
                        state_next = ST_MUL;
                    end
                end
                else if (accept)
                begin
                    if (echo)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = {HALF_BITS'(re), HALF_BITS'(im)};
                        out_last_next  = (pos_reg != LAST_POS);
                    end
                    if (pos_reg == LAST_POS)
                    begin
                        // symbol complete: advance the frame and read it out
                        pos_next    = '0;
                        left_next   = left_reg - FIELD_BITS'(1);
                        phase_next  = (left_reg != FIELD_BITS'(1));
                        rd_cnt_next = '0;
                        state_next  = ST_DUMP;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_BITS'(1);
                    end
                end
            end

            ST_MUL:
            begin
                prod_next = frame_len_reg * symbols_reg;
                if (pilot_reg == '0)
                begin
                    left_next  = '0;
                    phase_next = 1'b0;
                    state_next = ST_RUN;
                end
                else
                begin
                    state_next = ST_DIV1;
                end
            end

            ST_DIV1:
            begin
                if (div_rsp.done)
                begin
                    if (carriers == '0)
                    begin
                        left_next  = '0;
                        phase_next = 1'b0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_DIV2;
                    end
                end
            end

            ST_DIV2:
            begin
                if (div_rsp.done)
                begin
                    left_next  = div_rsp.quotient;
                    phase_next = (div_rsp.quotient != '0);
                    state_next = ST_RUN;
                end
            end

            ST_DUMP:
            begin
                if (push)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = {HALF_BITS'(rd_re), HALF_BITS'(rd_im)};
                    out_last_next  = pend_last_reg;
                    if (pend_last_reg)
                    begin
                        state_next = ST_RUN;
                    end
                end
                if (issue)
                begin
                    rd_cnt_next    = rd_cnt_reg + CNT_BITS'(1);
                    pend_last_next = (rd_cnt_reg == CNT_BITS'(SYMBOL_LEN - 1));
                end
                pend_next = issue || (pend_reg && !push);
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            phase_reg     <= 1'b0;
            frame_len_reg <= '0;
            symbols_reg   <= '0;
            pilot_reg     <= '0;
            prefix_reg    <= '0;
            left_reg      <= '0;
            prod_reg      <= '0;
            pos_reg       <= '0;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            frame_len_reg <= frame_len_next;
            symbols_reg   <= symbols_next;
            pilot_reg     <= pilot_next;
            prefix_reg    <= prefix_next;
            left_reg      <= left_next;
            prod_reg      <= prod_next;
            pos_reg       <= pos_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Samples are written on acceptance; readout starts the cycle after the
    // last write, so no read can meet a write to the same entry.
    cpi_buf #(
        .DEPTH (SYMBOL_LEN),
        .WIDTH (ENTRY_BITS)
    ) u_buf (
        .clk     (clk),
        .wr_en   (accept && phase_reg),
        .wr_addr (pos_reg),
        .wr_data ({re, im}),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[POS_BITS-1:0]),
        .rd_data (rd_data)
    );

    cpi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.out_word    = out_word_reg;
    assign result_ch.last_of_run = out_last_reg;

endmodule

// ===== verif/cyclic_prefix_inserter_tb.sv =====
// Self-checking testbench for the cyclic prefix inserter: header parsing, prefix echo, readout.
`timescale 1ns / 1ps

module cyclic_prefix_inserter_tb;
    import cpi_pkg::*;

    localparam int SYMBOL_LEN       = 32;
    localparam int SAMPLE_BITS      = 16;
    localparam int OWN_MODULE_ID    = 5;
    localparam int MODULE_ID_BITS   = 8;
    localparam int PARAM_ID_BITS    = 24;
    localparam int PARAM_VALUE_BITS = 32;

    // Module id field sits above the parameter id and the value
    localparam int MID_LSB = PARAM_ID_BITS + PARAM_VALUE_BITS;
    localparam logic [MODULE_ID_BITS-1:0] OWN_ID = MODULE_ID_BITS'(OWN_MODULE_ID);
    localparam logic [MODULE_ID_BITS-1:0] END_ID = '1;

    localparam int RANDOM_ITEMS = 120;
    localparam int TAIL_CYCLES  = 40;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last;
    } cp_word_t;

    logic clk;
    logic rst_n;

    cpi_in_if  in_ch ();
    cpi_out_if out_ch ();

    cyclic_prefix_inserter #(
        .SYMBOL_LEN       (SYMBOL_LEN),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .OWN_MODULE_ID    (OWN_MODULE_ID),
        .MODULE_ID_BITS   (MODULE_ID_BITS),
        .PARAM_ID_BITS    (PARAM_ID_BITS),
        .PARAM_VALUE_BITS (PARAM_VALUE_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (in_ch),
        .result_ch (out_ch)
    );

    // ------------------------------------------------------------------
    // Mirror of the inserter: frame parameters, symbol position and the
    // symbol buffer, kept in step with every item the block accepts.
    // ------------------------------------------------------------------
    logic                        in_frame;
    logic [PARAM_VALUE_BITS-1:0] frame_len_m;
    logic [PARAM_VALUE_BITS-1:0] symbols_m;
    logic [PARAM_VALUE_BITS-1:0] pilot_m;
    logic [PARAM_VALUE_BITS-1:0] prefix_m;
    logic [31:0]                 symbols_left_m;
    int unsigned                 slot_m;
    logic [SAMPLE_BITS-1:0]      re_buf [SYMBOL_LEN];
    logic [SAMPLE_BITS-1:0]      im_buf [SYMBOL_LEN];

    // Output words still owed by the block, oldest first
    cp_word_t out_words_due [$];

    bit idle_on;
    int items_sent;
    int results_checked;
    int frames_run;
    int symbols_done;
    int mismatches;

    // Clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [WORD_BITS-1:0] header_word(
        input logic [MODULE_ID_BITS-1:0]   mid,
        input logic [PARAM_ID_BITS-1:0]    pid,
        input logic [PARAM_VALUE_BITS-1:0] val);
        return {mid, pid, val};
    endfunction

    // Real part in the upper half, imaginary in the lower, both zero-extended
    function automatic logic [WORD_BITS-1:0] sample_word(
        input logic [SAMPLE_BITS-1:0] re,
        input logic [SAMPLE_BITS-1:0] im);
        return (WORD_BITS'(re) << HALF_BITS) | WORD_BITS'(im);
    endfunction

    // Symbols in the coming frame; product wraps at 32 bits, divide truncates
    function automatic logic [31:0] frame_symbol_count();
        logic [31:0] div;
        logic [31:0] prod;
        if (pilot_m == 0)
            return 0;
        div = SYMBOL_LEN - SYMBOL_LEN / pilot_m;
        if (div == 0)
            return 0;
        prod = frame_len_m * symbols_m;
        return prod / div;
    endfunction

    // Advance the mirror by one accepted item and queue the words it owes
    function automatic void insert_prefix(input logic [WORD_BITS-1:0] w);
        logic [MODULE_ID_BITS-1:0]   mid;
        logic [PARAM_ID_BITS-1:0]    pid;
        logic [PARAM_VALUE_BITS-1:0] val;
        logic [SAMPLE_BITS-1:0]      re;
        logic [SAMPLE_BITS-1:0]      im;
        int unsigned                 pos;
        bit                          echo;
        bit                          closes;
        int                          i;
        mid = w[WORD_BITS-1:MID_LSB];
        if (!in_frame)
        begin
            pid = w[MID_LSB-1:PARAM_VALUE_BITS];
            val = w[PARAM_VALUE_BITS-1:0];
            // Absorb our own words; unknown ids change nothing
            if (mid == OWN_ID)
            begin
                case (pid)
                    PARAM_ID_BITS'(PID_FRAME_LEN):  frame_len_m = val;
                    PARAM_ID_BITS'(PID_SYMBOLS):    symbols_m   = val;
                    PARAM_ID_BITS'(PID_PILOT):      pilot_m     = val;
                    PARAM_ID_BITS'(PID_PREFIX_LEN): prefix_m    = val;
                    default: ;
                endcase
            end
            else
                out_words_due.push_back('{w, 1'b1});
            // All-ones id closes the header; a frame of zero symbols stays in it
            if (mid == END_ID)
            begin
                symbols_left_m = frame_symbol_count();
                slot_m         = 0;
                in_frame       = (symbols_left_m != 0);
                if (in_frame)
                    frames_run++;
            end
            return;
        end

        pos = slot_m;
        re  = w[HALF_BITS +: SAMPLE_BITS];
        im  = w[0 +: SAMPLE_BITS];
        re_buf[pos] = re;
        im_buf[pos] = im;
        closes = (pos == SYMBOL_LEN - 1);
        // Compare at 64 bits so a huge prefix cannot wrap around
        echo = (64'(pos) + 64'(prefix_m)) >= 64'(SYMBOL_LEN);

        if (echo)
            out_words_due.push_back('{sample_word(re, im), !closes});
        if (closes)
        begin
            // Emit the whole symbol; flag only its final word
            for (i = 0; i < SYMBOL_LEN; i++)
                out_words_due.push_back('{sample_word(re_buf[i], im_buf[i]),
                                          i == SYMBOL_LEN - 1});
            slot_m = 0;
            symbols_left_m--;
            symbols_done++;
            if (symbols_left_m == 0)
                in_frame = 1'b0;
        end
        else
            slot_m = pos + 1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random word that is neither ours nor the end marker: it must pass through
    function automatic logic [WORD_BITS-1:0] passthru_word();
        logic [WORD_BITS-1:0] w;
        w = {$urandom, $urandom};
        while (w[WORD_BITS-1:MID_LSB] == OWN_ID || w[WORD_BITS-1:MID_LSB] == END_ID)
            w[WORD_BITS-1:MID_LSB] = MODULE_ID_BITS'($urandom);
        return w;
    endfunction

    // Sample with random bits everywhere; sometimes dress it as a header word,
    // which must still count as a sample inside a frame
    function automatic logic [WORD_BITS-1:0] sample_item();
        logic [WORD_BITS-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       w[WORD_BITS-1:MID_LSB] = END_ID;
            1:       w[WORD_BITS-1:MID_LSB] = OWN_ID;
            default: ;
        endcase
        return w;
    endfunction

    // Send one item. Valid stays high between back-to-back items and drops
    // only for an idle burst, so it never takes two assignments in one step.
    task automatic send_word(input logic [WORD_BITS-1:0] w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_word <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        insert_prefix(w);
        items_sent++;
    endtask

    // One frame: parameter words with noise mixed in, the end marker, then
    // samples for as long as the mirror says the frame lasts.
    task automatic run_frame(input logic [31:0] frame_len, input logic [31:0] spf,
                             input logic [31:0] pilot, input logic [31:0] prefix,
                             input bit full_setup, input int noise);
        logic [WORD_BITS-1:0]     setup [$];
        logic [WORD_BITS-1:0]     w;
        logic [PARAM_ID_BITS-1:0] pid;
        int                       k;
        // Length and count are always sent: stale values could make a huge frame
        setup.push_back(header_word(OWN_ID, PARAM_ID_BITS'(PID_FRAME_LEN), frame_len));
        setup.push_back(header_word(OWN_ID, PARAM_ID_BITS'(PID_SYMBOLS), spf));
        if (full_setup || $urandom_range(0, 3) != 0)
            setup.push_back(header_word(OWN_ID, PARAM_ID_BITS'(PID_PILOT), pilot));
        if (full_setup || $urandom_range(0, 3) != 0)
            setup.push_back(header_word(OWN_ID, PARAM_ID_BITS'(PID_PREFIX_LEN), prefix));
        for (k = 0; k < noise; k++)
        begin
            if ($urandom_range(0, 1) == 0)
                w = passthru_word();
            else
            begin
                pid = PARAM_ID_BITS'($urandom);
                if (pid <= PID_PREFIX_LEN)
                    pid = '1;
                w = header_word(OWN_ID, pid, $urandom);
            end
            setup.insert($urandom_range(0, setup.size()), w);
        end
        foreach (setup[k])
            send_word(setup[k]);
        send_word(header_word(END_ID, PARAM_ID_BITS'($urandom), $urandom));
        while (in_frame)
            send_word(sample_item());
    endtask

    task automatic random_frame();
        logic [31:0] frame_len;
        logic [31:0] spf;
        logic [31:0] pilot;
        logic [31:0] prefix;
        logic [31:0] swap;
        frame_len = $urandom_range(0, 36);
        spf       = ($urandom_range(0, 3) == 0) ? 2 : 1;
        if ($urandom_range(0, 1) == 1)
        begin
            swap      = frame_len;
            frame_len = spf;
            spf       = swap;
        end
        // Zero and one spacing give zero-symbol frames; the rest give divisors 16..32
        case ($urandom_range(0, 7))
            0:       pilot = 0;
            1:       pilot = 1;
            2:       pilot = 2;
            3:       pilot = 4;
            4:       pilot = 8;
            5:       pilot = SYMBOL_LEN;
            6:       pilot = $urandom_range(SYMBOL_LEN + 1, 1000);
            default: pilot = '1;
        endcase
        case ($urandom_range(0, 5))
            0:       prefix = 0;
            1:       prefix = 1;
            2:       prefix = SYMBOL_LEN - 1;
            3:       prefix = SYMBOL_LEN;
            4:       prefix = '1;
            default: prefix = $urandom_range(2, SYMBOL_LEN - 2);
        endcase
        run_frame(frame_len, spf, pilot, prefix, 1'b0, $urandom_range(0, 3));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Header phase only: forwarding, absorption, unknown ids and frames that end up
    // with zero symbols through zero spacing, a zero divisor or a zero product
    task automatic test_header_words();
        send_word(header_word(8'h00, '0, '0));
        send_word({8'hFE, {(WORD_BITS - MODULE_ID_BITS){1'b1}}});
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_FRAME_LEN), 32'hFFFF_FFFF));
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_SYMBOLS), 32'hFFFF_FFFF));
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_PILOT), 32'h0));
        // Zero pilot spacing
        send_word(header_word(END_ID, '0, '0));
        // Spacing of one leaves a zero divisor
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_PILOT), 32'h1));
        send_word({WORD_BITS{1'b1}});
        // Unknown parameter ids are absorbed without effect
        send_word(header_word(OWN_ID, '1, 32'hFFFF_FFFF));
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_PREFIX_LEN + 1), 32'h0));
        // Product wraps to zero
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_FRAME_LEN), 32'h8000_0000));
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_SYMBOLS), 32'h2));
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_PILOT), 32'h2));
        send_word(header_word(END_ID, PARAM_ID_BITS'($urandom), $urandom));
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_PREFIX_LEN), 32'hFFFF_FFFF));
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_PREFIX_LEN), 32'h0));
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_FRAME_LEN), 32'h0));
        send_word(header_word(OWN_ID, PARAM_ID_BITS'(PID_SYMBOLS), 32'h0));
        send_word(passthru_word());
        // Zero length
        send_word(header_word(END_ID, '1, '1));
    endtask

    // One-symbol frames with no prefix and with a prefix past the symbol
    task automatic test_prefix_extremes();
        run_frame(SYMBOL_LEN - 1, 1, SYMBOL_LEN, 32'h0, 1'b1, 0);
        run_frame(SYMBOL_LEN - 1, 1, SYMBOL_LEN, 32'hFFFF_FFFF, 1'b1, 1);
    endtask

    task automatic test_random_frames();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
            random_frame();
    endtask

    // Full rate on both sides for the closing frames
    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (2)
            random_frame();
    endtask

    // ------------------------------------------------------------------
    // Result checking: compare each accepted word with the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cp_word_t due;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (out_words_due.size() == 0)
                report_mismatch($sformatf("unexpected word %h last %b",
                                          out_ch.out_word, out_ch.last_of_run));
            else
            begin
                due = out_words_due.pop_front();
                results_checked++;
                if (out_ch.out_word !== due.word)
                    report_mismatch($sformatf("out_word %h, want %h",
                                              out_ch.out_word, due.word));
                if (out_ch.last_of_run !== due.last)
                    report_mismatch($sformatf("last_of_run %b, want %b on word %h",
                                              out_ch.last_of_run, due.last, due.word));
            end
        end
    end

    // Output side: hold ready high, drop it now and then for a short burst
    initial
    begin
        out_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_word <= '0;
        idle_on         = 1'b1;
        items_sent      = 0;
        results_checked = 0;
        frames_run      = 0;
        symbols_done    = 0;
        mismatches      = 0;
        in_frame        = 1'b0;
        frame_len_m     = '0;
        symbols_m       = '0;
        pilot_m         = '0;
        prefix_m        = '0;
        symbols_left_m  = '0;
        slot_m          = 0;
        foreach (re_buf[i])
        begin
            re_buf[i] = '0;
            im_buf[i] = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_words();
        test_prefix_extremes();
        test_random_frames();
        test_back_to_back();

        // Drain: wait for every owed word, then watch for strays
        in_ch.valid <= 1'b0;
        while (out_words_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items over %0d data frames (%0d symbols); checked %0d words.",
                 items_sent, frames_run, symbols_done, results_checked);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
